### hdl/dpcf_pkg.sv
package dpcf_pkg;

  localparam int MAX_PARTICLES = 64;
  localparam int IDX_W = $clog2(MAX_PARTICLES);
  localparam int CNT_W = $clog2(MAX_PARTICLES + 1);

  localparam int VAL_W = 32;
  localparam int RAD_W = 31;
  localparam int FRC_W = 48;
  localparam int CFG_W = 32;
  localparam int CFG_IDX_W = 1;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING = 1'd1;

  localparam logic [CFG_W-1:0] STIFFNESS_RESET = 32'd65536;
  localparam logic [CFG_W-1:0] DAMPING_RESET = 32'd0;

  localparam logic [30:0] NORM_ONE = 31'h4000_0000;
  localparam logic signed [FRC_W-1:0] F48MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [FRC_W-1:0] F48MIN = 48'sh8000_0000_0000;

  typedef struct packed {
    logic signed [VAL_W-1:0] pos_x;
    logic signed [VAL_W-1:0] pos_y;
    logic signed [VAL_W-1:0] pos_z;
    logic signed [VAL_W-1:0] vel_x;
    logic signed [VAL_W-1:0] vel_y;
    logic signed [VAL_W-1:0] vel_z;
    logic [RAD_W-1:0] particle_radius;
    logic signed [FRC_W-1:0] force_in_x;
    logic signed [FRC_W-1:0] force_in_y;
    logic signed [FRC_W-1:0] force_in_z;
    logic last_particle;
  } particle_t;

  typedef struct packed {
    logic signed [FRC_W-1:0] force_out_x;
    logic signed [FRC_W-1:0] force_out_y;
    logic signed [FRC_W-1:0] force_out_z;
    logic last_result;
  } force_t;

  typedef struct packed {
    logic [2:0][VAL_W-1:0] pos;
    logic [2:0][VAL_W-1:0] vel;
    logic [RAD_W-1:0] rad;
  } entry_t;

  typedef logic [2:0][FRC_W-1:0] fvec_t;

  // clamp a widened force sum to the 48-bit signed range
  function automatic logic [FRC_W-1:0] sat48(input logic signed [FRC_W+1:0] v);
    logic [FRC_W-1:0] r;
    if (v > $signed({{2{F48MAX[FRC_W-1]}}, F48MAX})) r = F48MAX;
    else if (v < $signed({{2{F48MIN[FRC_W-1]}}, F48MIN})) r = F48MIN;
    else r = v[FRC_W-1:0];
    return r;
  endfunction

endpackage

### hdl/dpcf_if.sv
interface dpcf_in_if;
  logic valid;
  logic ready;
  dpcf_pkg::particle_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dpcf_out_if;
  logic valid;
  logic ready;
  dpcf_pkg::force_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/dem_pair_contact_forces.sv
// Normal contact forces between up to 64 stored particles.
// Channel particles: one word per particle, taken one a cycle while the
// block is loading. The word flagged last closes the set; words beyond
// capacity are dropped but their last flag still counts.
// Channel forces: one word per stored particle, in load order, last_result
// on the final one. A result sits in an output register, so a stalled
// receiver holds only that word; the sequencer waits on it.
// Registers kn (stiffness) and gamma (damping) are written through the
// plain port (cfg_we, cfg_idx, cfg_data); the user must write them only
// while the block is idle, which the block itself does not enforce.
// Each pair is read from the particle memory and rejected early when the
// spheres are clearly apart, or after the square root when only it shows
// they do not touch; a touching pair goes through the 32-step square root
// and the 62-step divider run once per axis. Forces are then read from the
// force memory one word at a time into the output register.
// Reset empties the set, clears the output valid flag and restores the
// register defaults; memory contents are left as they are.
module dem_pair_contact_forces (
  input logic clk,
  input logic rst,
  dpcf_in_if.sink particles,
  dpcf_out_if.source forces,
  input logic cfg_we,
  input logic [dpcf_pkg::CFG_IDX_W-1:0] cfg_idx,
  input logic [dpcf_pkg::CFG_W-1:0] cfg_data
);

  localparam logic [4:0] S_LOAD = 5'd0, S_RD = 5'd1, S_DIFF = 5'd2, S_CHK = 5'd3,
    S_SQ = 5'd4, S_SQACC = 5'd5, S_RS = 5'd6, S_RSCHK = 5'd7, S_SQRT = 5'd8,
    S_DCHK = 5'd9, S_DIVINIT = 5'd10, S_DIV = 5'd11, S_DIVEND = 5'd12,
    S_VN = 5'd13, S_VNACC = 5'd14, S_SPR = 5'd15, S_SPRGET = 5'd16,
    S_DMP = 5'd17, S_DMPGET = 5'd18, S_FLO = 5'd19, S_FHI = 5'd20,
    S_FSUM = 5'd21, S_FRD = 5'd22, S_FWI = 5'd23, S_FWJ = 5'd24,
    S_NEXT = 5'd25, S_ERD = 5'd26, S_EOUT = 5'd27;

  localparam int IW = dpcf_pkg::IDX_W;
  localparam int CW = dpcf_pkg::CNT_W;
  localparam logic [CW-1:0] MAXC = CW'(dpcf_pkg::MAX_PARTICLES);

  logic [4:0] state;
  logic [CW-1:0] count, n, e;
  logic [IW-1:0] pi, pj;
  logic [1:0] k;
  logic [5:0] cnt;

  logic [31:0] kn, gamma;

  logic [2:0][32:0] a, dvm;
  logic [2:0] rneg, dvneg;
  logic [31:0] rsum, sep, delta;
  logic [63:0] d2, sq_v, sq_r, sq_bit;
  logic [61:0] div_num, div_q;
  logic [31:0] div_rem;
  logic [2:0][30:0] nm;
  logic signed [35:0] vn;
  logic [47:0] spring;
  logic [46:0] fnc;
  logic [62:0] facc;
  logic [2:0][46:0] f;
  logic [71:0] prod;
  logic [35:0] mul_a, mul_b;
  dpcf_pkg::fvec_t newi, newj;

  dpcf_pkg::entry_t pmem [dpcf_pkg::MAX_PARTICLES];
  dpcf_pkg::fvec_t fmem [dpcf_pkg::MAX_PARTICLES];
  dpcf_pkg::entry_t pa, pb;
  dpcf_pkg::fvec_t fa, fb;

  logic ov;
  dpcf_pkg::force_t odata;

  logic acc, room, out_load, fwe;
  logic [IW-1:0] fwaddr, faddr;
  dpcf_pkg::fvec_t fwdata;
  logic [CW-1:0] cnt_after;

  assign particles.ready = (state == S_LOAD);
  assign acc = particles.valid && (state == S_LOAD);
  assign room = (count < MAXC);
  assign cnt_after = room ? count + CW'(1) : count;
  assign out_load = (state == S_EOUT) && (!ov || forces.ready);
  assign forces.valid = ov;
  assign forces.data = odata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      kn <= dpcf_pkg::STIFFNESS_RESET;
      gamma <= dpcf_pkg::DAMPING_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        dpcf_pkg::REG_STIFFNESS: kn <= cfg_data;
        dpcf_pkg::REG_DAMPING: gamma <= cfg_data;
        default: ;
      endcase
    end
  end

  // particle memory: written on load, read at pair indexes
  always_ff @(posedge clk) begin
    if (acc && room) begin
      pmem[count[IW-1:0]] <= '{
        pos: {particles.data.pos_z, particles.data.pos_y, particles.data.pos_x},
        vel: {particles.data.vel_z, particles.data.vel_y, particles.data.vel_x},
        rad: particles.data.particle_radius};
    end
    pa <= pmem[pi];
    pb <= pmem[pj];
  end

  // force memory: single write port, two registered reads
  always_comb begin
    fwe = 1'b0;
    fwaddr = pi;
    fwdata = newi;
    priority if (acc && room) begin
      fwe = 1'b1;
      fwaddr = count[IW-1:0];
      fwdata = {particles.data.force_in_z, particles.data.force_in_y,
                particles.data.force_in_x};
    end else if (state == S_FWI) begin
      fwe = 1'b1;
    end else if (state == S_FWJ) begin
      fwe = 1'b1;
      fwaddr = pj;
      fwdata = newj;
    end
  end

  assign faddr = (state == S_ERD || state == S_EOUT) ? e[IW-1:0] : pi;

  always_ff @(posedge clk) begin
    if (fwe) fmem[fwaddr] <= fwdata;
    fa <= fmem[faddr];
    fb <= fmem[pj];
  end

  // shared multiplier, registered
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_SQ: begin mul_a = {3'b0, a[k]}; mul_b = {3'b0, a[k]}; end
      S_RS: begin mul_a = {4'b0, rsum}; mul_b = {4'b0, rsum}; end
      S_VN: begin mul_a = {3'b0, dvm[k]}; mul_b = {5'b0, nm[k]}; end
      S_SPR: begin mul_a = {4'b0, kn}; mul_b = {4'b0, delta}; end
      S_DMP: begin
        mul_a = {4'b0, gamma};
        mul_b = vn[35] ? 36'(-vn) : 36'(vn);
      end
      S_FLO: begin mul_a = {4'b0, fnc[31:0]}; mul_b = {5'b0, nm[k]}; end
      S_FHI: begin mul_a = {21'b0, fnc[46:32]}; mul_b = {5'b0, nm[k]}; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) prod <= mul_a * mul_b;

  // pair-phase datapath terms
  logic signed [32:0] rdiff [3];
  logic signed [32:0] vdiff [3];
  logic [64:0] d2_sum;
  logic [63:0] sq_t;
  logic [32:0] div_rs;
  logic [33:0] vn_t;
  logic [51:0] damp;
  logic signed [53:0] fn;
  logic [77:0] f_full;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rdiff[c] = $signed({pb.pos[c][31], pb.pos[c]}) - $signed({pa.pos[c][31], pa.pos[c]});
      vdiff[c] = $signed({pb.vel[c][31], pb.vel[c]}) - $signed({pa.vel[c][31], pa.vel[c]});
    end
    d2_sum = {1'b0, d2} + {1'b0, prod[63:0]};
    sq_t = sq_r + sq_bit;
    div_rs = {div_rem, div_num[61]};
    vn_t = prod[63:30];
    damp = prod[67:16];
    fn = vn[35] ? $signed({6'b0, spring}) + $signed({2'b0, damp})
                : $signed({6'b0, spring}) - $signed({2'b0, damp});
    f_full = {15'b0, facc} + {prod[45:0], 32'b0};
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      count <= '0;
      n <= '0;
      e <= '0;
      pi <= '0;
      pj <= '0;
      k <= '0;
      cnt <= '0;
    end else begin
      unique case (state)
        S_LOAD: if (acc) begin
          count <= cnt_after;
          if (particles.data.last_particle) begin
            n <= cnt_after;
            pi <= '0;
            pj <= IW'(1);
            e <= '0;
            state <= (cnt_after < CW'(2)) ? S_ERD : S_RD;
          end
        end
        S_RD: state <= S_DIFF;
        S_DIFF: state <= S_CHK;
        S_CHK: begin
          k <= '0;
          if (a[0] >= {1'b0, rsum} || a[1] >= {1'b0, rsum} || a[2] >= {1'b0, rsum})
            state <= S_NEXT;
          else state <= S_SQ;
        end
        S_SQ: state <= S_SQACC;
        S_SQACC: begin
          if (d2_sum[64]) state <= S_NEXT;
          else if (k == 2'd2) state <= S_RS;
          else begin
            k <= k + 2'd1;
            state <= S_SQ;
          end
        end
        S_RS: state <= S_RSCHK;
        S_RSCHK: begin
          cnt <= '0;
          state <= (d2 >= prod[63:0] || d2 == '0) ? S_NEXT : S_SQRT;
        end
        S_SQRT: begin
          cnt <= cnt + 6'd1;
          if (cnt == 6'd31) state <= S_DCHK;
        end
        S_DCHK: begin
          k <= '0;
          state <= (sq_r[31:0] == '0 || sq_r[31:0] >= rsum) ? S_NEXT : S_DIVINIT;
        end
        S_DIVINIT: begin
          cnt <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          cnt <= cnt + 6'd1;
          if (cnt == 6'd61) state <= S_DIVEND;
        end
        S_DIVEND: state <= S_VN;
        S_VN: state <= S_VNACC;
        S_VNACC: begin
          if (k == 2'd2) state <= S_SPR;
          else begin
            k <= k + 2'd1;
            state <= S_DIVINIT;
          end
        end
        S_SPR: state <= S_SPRGET;
        S_SPRGET: state <= S_DMP;
        S_DMP: state <= S_DMPGET;
        S_DMPGET: begin
          k <= '0;
          state <= (fn <= 54'sd0) ? S_NEXT : S_FLO;
        end
        S_FLO: state <= S_FHI;
        S_FHI: state <= S_FSUM;
        S_FSUM: begin
          if (k == 2'd2) state <= S_FRD;
          else begin
            k <= k + 2'd1;
            state <= S_FLO;
          end
        end
        S_FRD: state <= S_FWI;
        S_FWI: state <= S_FWJ;
        S_FWJ: state <= S_NEXT;
        S_NEXT: begin
          // advance j, then i, then hand over to the result sweep
          priority if ({1'b0, pj} + CW'(1) < n) begin
            pj <= pj + IW'(1);
            state <= S_RD;
          end else if ({1'b0, pi} + CW'(2) < n) begin
            pi <= pi + IW'(1);
            pj <= pi + IW'(2);
            state <= S_RD;
          end else begin
            e <= '0;
            state <= S_ERD;
          end
        end
        S_ERD: state <= S_EOUT;
        S_EOUT: if (out_load) begin
          if (e + CW'(1) == n) begin
            count <= '0;
            state <= S_LOAD;
          end else begin
            e <= e + CW'(1);
            state <= S_ERD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_DIFF: begin
        for (int c = 0; c < 3; c++) begin
          rneg[c] <= rdiff[c][32];
          a[c] <= rdiff[c][32] ? 33'(-rdiff[c]) : 33'(rdiff[c]);
          dvneg[c] <= vdiff[c][32];
          dvm[c] <= vdiff[c][32] ? 33'(-vdiff[c]) : 33'(vdiff[c]);
        end
        rsum <= {1'b0, pa.rad} + {1'b0, pb.rad};
        d2 <= '0;
      end
      S_SQACC: d2 <= d2_sum[63:0];
      S_RSCHK: begin
        sq_v <= d2;
        sq_r <= '0;
        sq_bit <= 64'h4000_0000_0000_0000;
      end
      S_SQRT: begin
        if (sq_v >= sq_t) begin
          sq_v <= sq_v - sq_t;
          sq_r <= (sq_r >> 1) + sq_bit;
        end else begin
          sq_r <= sq_r >> 1;
        end
        sq_bit <= sq_bit >> 2;
      end
      S_DCHK: begin
        sep <= sq_r[31:0];
        delta <= rsum - sq_r[31:0];
        vn <= '0;
      end
      S_DIVINIT: begin
        div_num <= {a[k][31:0], 30'b0};
        div_rem <= '0;
        div_q <= '0;
      end
      S_DIV: begin
        if (div_rs >= {1'b0, sep}) begin
          div_rem <= 32'(div_rs - {1'b0, sep});
          div_q <= {div_q[60:0], 1'b1};
        end else begin
          div_rem <= div_rs[31:0];
          div_q <= {div_q[60:0], 1'b0};
        end
        div_num <= {div_num[60:0], 1'b0};
      end
      S_DIVEND: nm[k] <= (div_q > {31'b0, dpcf_pkg::NORM_ONE}) ? dpcf_pkg::NORM_ONE
                                                                  : div_q[30:0];
      S_VNACC: begin
        if (dvneg[k] != rneg[k]) vn <= vn - $signed({2'b0, vn_t});
        else vn <= vn + $signed({2'b0, vn_t});
      end
      S_SPRGET: spring <= prod[63:16];
      S_DMPGET: fnc <= (fn > 54'sh7FFF_FFFF_FFFF) ? 47'h7FFF_FFFF_FFFF : fn[46:0];
      S_FHI: facc <= prod[62:0];
      S_FSUM: f[k] <= f_full[76:30];
      S_FRD: begin
        for (int c = 0; c < 3; c++) begin
          if (rneg[c]) begin
            newi[c] <= dpcf_pkg::sat48($signed({{2{fa[c][47]}}, fa[c]}) + $signed({3'b0, f[c]}));
            newj[c] <= dpcf_pkg::sat48($signed({{2{fb[c][47]}}, fb[c]}) - $signed({3'b0, f[c]}));
          end else begin
            newi[c] <= dpcf_pkg::sat48($signed({{2{fa[c][47]}}, fa[c]}) - $signed({3'b0, f[c]}));
            newj[c] <= dpcf_pkg::sat48($signed({{2{fb[c][47]}}, fb[c]}) + $signed({3'b0, f[c]}));
          end
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) ov <= 1'b0;
    else if (out_load) ov <= 1'b1;
    else if (forces.ready) ov <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      odata.force_out_x <= fa[0];
      odata.force_out_y <= fa[1];
      odata.force_out_z <= fa[2];
      odata.last_result <= (e + CW'(1) == n);
    end
  end

endmodule

### hdl/dpcf_checker.sv
module dpcf_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic in_last,
  input logic out_valid,
  input logic out_ready,
  input dpcf_pkg::force_t out_data
);

  // a waiting word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // a waiting word keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result word changed while stalled");

  // the closing particle always ends the load phase
  a_last_stops_load: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("load continued after the closing particle");

  // while loading, only the final word of the previous set may wait
  a_load_after_sweep: assert property (@(posedge clk) disable iff (rst)
    in_ready && out_valid |-> out_data.last_result)
    else $error("load resumed before all results were issued");

endmodule

bind dem_pair_contact_forces dpcf_checker u_dpcf_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(particles.valid),
  .in_ready(particles.ready),
  .in_last(particles.data.last_particle),
  .out_valid(forces.valid),
  .out_ready(forces.ready),
  .out_data(forces.data)
);

### bench/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int CYCLE_LIMIT = 3_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [dpcf_pkg::CFG_IDX_W-1:0] cfg_idx = dpcf_pkg::REG_STIFFNESS;
  logic [dpcf_pkg::CFG_W-1:0] cfg_data = '0;

  dpcf_in_if pin ();
  dpcf_out_if pout ();

  dem_pair_contact_forces dut (
    .clk(clk), .rst(rst), .particles(pin), .forces(pout),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // shadow of the block: stores, count and registers
  logic signed [63:0] sh_pos [dpcf_pkg::MAX_PARTICLES][3];
  logic signed [63:0] sh_vel [dpcf_pkg::MAX_PARTICLES][3];
  logic signed [63:0] sh_frc [dpcf_pkg::MAX_PARTICLES][3];
  logic [63:0] sh_rad [dpcf_pkg::MAX_PARTICLES];
  int sh_count = 0;
  logic [63:0] sh_kn = 64'd65536;
  logic [63:0] sh_gamma = 64'd0;

  dpcf_pkg::particle_t particle_q [$];
  dpcf_pkg::force_t force_q [$];
  int errors = 0;
  int forces_seen = 0;
  int cycles = 0;

  function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int s);
    logic [127:0] pr;
    pr = {64'd0, a} * {64'd0, b};
    return pr[63 + s -: 64];
  endfunction

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] r, bit_w;
    r = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= r + bit_w) begin
        v = v - (r + bit_w);
        r = (r >> 1) + bit_w;
      end else begin
        r = r >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [63:0] clamp48(logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
    if (v < -64'sh8000_0000_0000) return -64'sh8000_0000_0000;
    return v;
  endfunction

  // add the contact force of pair i<j to both stored forces
  task automatic apply_contact(int i, int j);
    logic signed [63:0] r [3];
    logic [63:0] a [3], nm [3];
    logic [63:0] d2, sq, s, rsum, sep, delta, spring, damp, n, t, vmag;
    logic signed [63:0] vn, fn, dv, f;
    rsum = sh_rad[i] + sh_rad[j];
    d2 = 0;
    vn = 0;
    for (int k = 0; k < 3; k++) begin
      r[k] = sh_pos[j][k] - sh_pos[i][k];
      a[k] = r[k] < 0 ? -r[k] : r[k];
      if (a[k] >= rsum) return;
    end
    for (int k = 0; k < 3; k++) begin
      sq = a[k] * a[k];
      s = d2 + sq;
      if (s < d2) return;
      d2 = s;
    end
    if (d2 >= rsum * rsum || d2 == 0) return;
    sep = root64(d2);
    if (sep == 0 || sep >= rsum) return;
    delta = rsum - sep;
    for (int k = 0; k < 3; k++) begin
      n = (a[k] << 30) / sep;
      nm[k] = n > 64'd1073741824 ? 64'd1073741824 : n;
      dv = sh_vel[j][k] - sh_vel[i][k];
      vmag = dv < 0 ? -dv : dv;
      t = (vmag * nm[k]) >> 30;
      if ((dv < 0) != (r[k] < 0)) vn = vn - $signed(t);
      else vn = vn + $signed(t);
    end
    spring = (sh_kn * delta) >> 16;
    vmag = vn < 0 ? -vn : vn;
    damp = mul_shift(sh_gamma, vmag, 16);
    fn = $signed(spring) - (vn >= 0 ? $signed(damp) : -$signed(damp));
    if (fn <= 0) return;
    if (fn > 64'sh7FFF_FFFF_FFFF) fn = 64'sh7FFF_FFFF_FFFF;
    for (int k = 0; k < 3; k++) begin
      f = $signed(mul_shift(fn, nm[k], 30));
      if (r[k] < 0) f = -f;
      sh_frc[i][k] = clamp48(sh_frc[i][k] - f);
      sh_frc[j][k] = clamp48(sh_frc[j][k] + f);
    end
  endtask

  // store one particle; on the last word work out every force of the set
  task automatic predict_forces(dpcf_pkg::particle_t p);
    dpcf_pkg::force_t w;
    if (sh_count < dpcf_pkg::MAX_PARTICLES) begin
      sh_pos[sh_count] = '{64'(p.pos_x), 64'(p.pos_y), 64'(p.pos_z)};
      sh_vel[sh_count] = '{64'(p.vel_x), 64'(p.vel_y), 64'(p.vel_z)};
      sh_frc[sh_count] = '{64'(p.force_in_x), 64'(p.force_in_y), 64'(p.force_in_z)};
      sh_rad[sh_count] = {33'd0, p.particle_radius};
      sh_count++;
    end
    if (!p.last_particle) return;
    for (int i = 0; i + 1 < sh_count; i++)
      for (int j = i + 1; j < sh_count; j++) apply_contact(i, j);
    for (int i = 0; i < sh_count; i++) begin
      w.force_out_x = sh_frc[i][0][dpcf_pkg::FRC_W-1:0];
      w.force_out_y = sh_frc[i][1][dpcf_pkg::FRC_W-1:0];
      w.force_out_z = sh_frc[i][2][dpcf_pkg::FRC_W-1:0];
      w.last_result = (i + 1 == sh_count);
      force_q.push_back(w);
    end
    sh_count = 0;
  endtask

  // quiet window with no random idling on either side
  function automatic logic take_gap();
    if (cycles >= 30000 && cycles < 90000) return 1'b0;
    return $urandom_range(0, 99) < 7;
  endfunction

  // driver: hold the word until taken, then advance from the queue
  always @(posedge clk) begin
    if (rst) begin
      pin.valid <= 1'b0;
      pin.data <= '0;
    end else if (!pin.valid || pin.ready) begin
      if (pin.valid) predict_forces(pin.data);
      if (particle_q.size() > 0 && !take_gap()) begin
        pin.data <= particle_q.pop_front();
        pin.valid <= 1'b1;
      end else begin
        pin.valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, once, while the sender keeps offering
  int hold_left = 0;
  logic hold_done = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (!hold_done && forces_seen >= 30) begin
      hold_left <= 600;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor: compare each force word with the oldest expectation
  always @(posedge clk) begin
    dpcf_pkg::force_t e;
    if (rst) begin
      pout.ready <= 1'b0;
    end else begin
      if (pout.valid && pout.ready) begin
        forces_seen++;
        if (force_q.size() == 0) begin
          $error("unexpected force word %p", pout.data);
          errors++;
        end else begin
          e = force_q.pop_front();
          if (pout.data.force_out_x !== e.force_out_x) begin
            $error("force_out_x exp %h got %h", e.force_out_x, pout.data.force_out_x);
            errors++;
          end
          if (pout.data.force_out_y !== e.force_out_y) begin
            $error("force_out_y exp %h got %h", e.force_out_y, pout.data.force_out_y);
            errors++;
          end
          if (pout.data.force_out_z !== e.force_out_z) begin
            $error("force_out_z exp %h got %h", e.force_out_z, pout.data.force_out_z);
            errors++;
          end
          if (pout.data.last_result !== e.last_result) begin
            $error("last_result exp %b got %b", e.last_result, pout.data.last_result);
            errors++;
          end
        end
      end
      pout.ready <= (hold_left == 0) && !take_gap();
    end
  end

  // cycle counter and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[dem_pair_contact_forces] ERROR");
      $finish;
    end
  end

  function automatic dpcf_pkg::particle_t make_particle(logic [31:0] cx, logic [31:0] cy,
                                                        logic [31:0] cz, int scale,
                                                        logic last);
    dpcf_pkg::particle_t p;
    int sel;
    sel = $urandom_range(0, 99);
    p.pos_x = cx + $urandom_range(0, 2 * scale) - scale;
    p.pos_y = cy + $urandom_range(0, 2 * scale) - scale;
    p.pos_z = cz + $urandom_range(0, 2 * scale) - scale;
    if (sel < 60) begin
      p.vel_x = $urandom_range(0, 2 * scale) - scale;
      p.vel_y = $urandom_range(0, 2 * scale) - scale;
      p.vel_z = $urandom_range(0, 2 * scale) - scale;
    end else begin
      p.vel_x = $urandom;
      p.vel_y = $urandom;
      p.vel_z = $urandom;
    end
    p.particle_radius = (sel % 10 == 0) ? 31'($urandom) : 31'($urandom_range(scale / 2, scale));
    p.force_in_x = 48'({$urandom, $urandom} >> $urandom_range(16, 40));
    p.force_in_y = 48'({$urandom, $urandom});
    p.force_in_z = 48'({$urandom, $urandom} >> $urandom_range(0, 47));
    if ($urandom_range(0, 1)) p.force_in_x = -p.force_in_x;
    if ($urandom_range(0, 1)) p.force_in_z = -p.force_in_z;
    p.last_particle = last;
    return p;
  endfunction

  // queue one set of clustered particles, flagged last on the final one
  task automatic queue_cluster(int size, ref int queued);
    logic [31:0] cx, cy, cz;
    int scale;
    dpcf_pkg::particle_t p;
    logic [383:0] noise;
    cx = $urandom;
    cy = $urandom;
    cz = $urandom;
    scale = 1 << $urandom_range(4, 28);
    for (int k = 0; k < size; k++) begin
      p = make_particle(cx, cy, cz, scale, k == size - 1);
      // noise word: every field random but the last flag
      if ($urandom_range(0, 19) == 0) begin
        noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom, $urandom};
        p = noise[$bits(dpcf_pkg::particle_t)-1:0];
        p.last_particle = (k == size - 1);
      end
      particle_q.push_back(p);
      queued++;
    end
  endtask

  task automatic write_reg(logic [dpcf_pkg::CFG_IDX_W-1:0] idx,
                           logic [dpcf_pkg::CFG_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == dpcf_pkg::REG_STIFFNESS) sh_kn = {32'd0, v};
    else sh_gamma = {32'd0, v};
  endtask

  task automatic wait_drained();
    while (particle_q.size() > 0 || pin.valid || force_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic queue_directed();
    dpcf_pkg::particle_t p;
    // coincident centres
    p = '0;
    p.pos_x = 32'sd1000; p.particle_radius = 31'd70000; p.vel_x = 32'sh7FFF_FFFF;
    particle_q.push_back(p);
    p.vel_x = 32'sh8000_0000; p.last_particle = 1'b1;
    particle_q.push_back(p);
    // opposite position extremes, largest radii: squared distance overflows
    p = '0;
    p.pos_x = 32'sh8000_0000; p.pos_y = 32'sh8000_0000; p.pos_z = 32'sh8000_0000;
    p.particle_radius = 31'h7FFF_FFFF;
    particle_q.push_back(p);
    p.pos_x = 32'sh7FFF_FFFD; p.pos_y = 32'sh7FFF_FFFD; p.pos_z = 32'sh7FFF_FFFD;
    p.last_particle = 1'b1;
    particle_q.push_back(p);
    // far apart along one axis only
    p = '0;
    p.pos_x = 32'sh8000_0000; p.particle_radius = 31'd5;
    particle_q.push_back(p);
    p.pos_x = 32'sh7FFF_FFFF; p.last_particle = 1'b1;
    particle_q.push_back(p);
    // touching pair pushed into saturation from both force extremes
    p = '0;
    p.particle_radius = 31'h4000_0000; p.vel_y = 32'sh8000_0000;
    p.force_in_x = 48'sh7FFF_FFFF_FFFF; p.force_in_y = 48'sh8000_0000_0000;
    p.force_in_z = 48'sh7FFF_FFFF_FFFF;
    particle_q.push_back(p);
    p.pos_x = 32'sh0001_0000; p.pos_y = 32'shFFFF_0000; p.pos_z = 32'sh0000_8000;
    p.vel_y = 32'sh7FFF_FFFF; p.vel_z = 32'shFFFF_FFFF;
    p.force_in_x = 48'sh8000_0000_0000; p.force_in_y = 48'sh7FFF_FFFF_FFFF;
    p.force_in_z = 48'sh8000_0000_0000; p.last_particle = 1'b1;
    particle_q.push_back(p);
    // lone particle, zero radius
    p = '0;
    p.force_in_y = 48'sh0000_0001_0000; p.last_particle = 1'b1;
    particle_q.push_back(p);
    // three in a row, small overlaps
    p = '0;
    for (int k = 0; k < 3; k++) begin
      p.pos_z = k * 32'sh0001_8000; p.particle_radius = 31'h0001_0000;
      p.vel_z = -k * 32'sh0000_4000; p.last_particle = (k == 2);
      particle_q.push_back(p);
    end
  endtask

  // full store: spread particles, then words beyond capacity, last flagged
  task automatic queue_full_set(ref int queued);
    dpcf_pkg::particle_t p;
    for (int k = 0; k < dpcf_pkg::MAX_PARTICLES + 2; k++) begin
      p = make_particle($urandom, $urandom, $urandom, 16,
                        k == dpcf_pkg::MAX_PARTICLES + 1);
      if (k % 16 == 1) p.pos_x = particle_q[particle_q.size() - 1].pos_x + 32'sd4;
      if (k % 16 == 1) p.pos_y = particle_q[particle_q.size() - 1].pos_y;
      if (k % 16 == 1) p.pos_z = particle_q[particle_q.size() - 1].pos_z;
      particle_q.push_back(p);
      queued++;
    end
  endtask

  initial begin
    int queued;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        1: begin
          write_reg(dpcf_pkg::REG_STIFFNESS, 32'd0);
          write_reg(dpcf_pkg::REG_DAMPING, 32'd0);
        end
        2: begin
          write_reg(dpcf_pkg::REG_STIFFNESS, 32'hFFFF_FFFF);
          write_reg(dpcf_pkg::REG_DAMPING, 32'hFFFF_FFFF);
        end
        3: begin
          write_reg(dpcf_pkg::REG_STIFFNESS, dpcf_pkg::STIFFNESS_RESET);
          write_reg(dpcf_pkg::REG_DAMPING, $urandom_range(0, 32'h0004_0000));
        end
        4: begin
          write_reg(dpcf_pkg::REG_STIFFNESS, $urandom);
          write_reg(dpcf_pkg::REG_DAMPING, $urandom);
        end
        5: begin
          write_reg(dpcf_pkg::REG_STIFFNESS, $urandom);
          write_reg(dpcf_pkg::REG_DAMPING, dpcf_pkg::DAMPING_RESET);
        end
        default: queue_directed();
      endcase
      queued = 0;
      if (phase == 3) queue_full_set(queued);
      while (queued < 65)
        queue_cluster($urandom_range(0, 9) == 0 ? $urandom_range(9, 14) :
                      $urandom_range(1, 8), queued);
      wait_drained();
    end
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("[dem_pair_contact_forces] OK");
    end else begin
      $display("[dem_pair_contact_forces] ERROR");
    end
    $finish;
  end

endmodule

### files.f
hdl/dpcf_pkg.sv
hdl/dpcf_if.sv
hdl/dem_pair_contact_forces.sv
hdl/dpcf_checker.sv
bench/testbench.sv
